@@ src/dmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types, constants and tables for the affine matrix decomposition
// pipeline: the payload records that travel beside each chain of cells and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dmt_pkg;

  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 31;
  localparam int RY_STEPS   = 31;
  localparam int NORM_SHIFT = 30;

  localparam int DIV_REM_W = 63;
  localparam int DVS_W     = 32;
  localparam int QUO_W     = 31;

  localparam int XW = 34;
  localparam int ZW = 35;

  localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [ZW-1:0] ANGLE_MAX  = 35'sd205887;
  localparam logic signed [ZW-1:0] ROUND_HALF = 35'sd8192;
  localparam int ROUND_SHIFT = 14;

  typedef struct packed {
    logic signed [31:0] b0x;
    logic signed [31:0] b0y;
    logic signed [31:0] b0z;
    logic signed [31:0] b1z;
    logic signed [31:0] b2z;
    logic [2:0][31:0]   offset;
  } base_t;

  typedef struct packed {
    logic [2:0] d;
    base_t      base;
  } sqrt_side_t;

  typedef struct packed {
    logic [2:0]       d;
    logic [2:0][31:0] len;
    logic [4:0]       neg;
    logic [2:0][31:0] offset;
  } div_side_t;

  typedef struct packed {
    logic [2:0]       d;
    logic [2:0][31:0] len;
    logic [4:0][31:0] u;
    logic [2:0][31:0] offset;
  } ry_side_t;

  typedef struct packed {
    logic [2:0]       force_zero;
    logic             degen;
    logic [2:0][31:0] len;
    logic [2:0][31:0] offset;
  } cordic_side_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (32'd0 - 32'(v)) : 32'(v);
  endfunction

  function automatic logic [29:0] atan_q30(int unsigned i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837829;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      23: a = 30'd128;
      24: a = 30'd64;
      25: a = 30'd32;
      26: a = 30'd16;
      27: a = 30'd8;
      28: a = 30'd4;
      29: a = 30'd2;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

@@ src/dmt_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// dmt_sqrt_cell
// One digit step of a pipelined integer square root, applied to several
// lanes side by side, with a payload carried along unchanged.
// ----------------------------------------------------------------------------
module dmt_sqrt_cell #(
  parameter int LANES  = 3,
  parameter int W      = 64,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_in,
  input  logic [LANES-1:0][W-1:0]    rem_in,
  input  logic [LANES-1:0][W-1:0]    res_in,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       valid_out,
  output logic [LANES-1:0][W-1:0]    rem_out,
  output logic [LANES-1:0][W-1:0]    res_out,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int SH = W - 2 - 2 * STEP;
  localparam logic [W-1:0] BIT = W'(1) << SH;

  logic [LANES-1:0][W-1:0] rem_next;
  logic [LANES-1:0][W-1:0] res_next;

  always_comb begin
    logic [W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = res_in[l] + BIT;
      if (rem_in[l] >= trial) begin
        rem_next[l] = rem_in[l] - trial;
        res_next[l] = (res_in[l] >> 1) + BIT;
      end else begin
        rem_next[l] = rem_in[l];
        res_next[l] = res_in[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    res_out  <= res_next;
    side_out <= side_in;
  end

endmodule

@@ src/dmt_div_cell.sv @@
// ----------------------------------------------------------------------------
// dmt_div_cell
// One quotient bit of a pipelined restoring divider, applied to several
// lanes side by side, with a payload carried along unchanged.
// ----------------------------------------------------------------------------
module dmt_div_cell
  import dmt_pkg::*;
#(
  parameter int LANES  = 5,
  parameter int BIT    = 30,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid_in,
  input  logic [LANES-1:0][DIV_REM_W-1:0] rem_in,
  input  logic [LANES-1:0][DVS_W-1:0]     dvs_in,
  input  logic [LANES-1:0][QUO_W-1:0]     quo_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            valid_out,
  output logic [LANES-1:0][DIV_REM_W-1:0] rem_out,
  output logic [LANES-1:0][DVS_W-1:0]     dvs_out,
  output logic [LANES-1:0][QUO_W-1:0]     quo_out,
  output logic [SIDE_W-1:0]               side_out
);

  localparam logic [QUO_W-1:0] QBIT = QUO_W'(1) << BIT;

  logic [LANES-1:0][DIV_REM_W-1:0] rem_next;
  logic [LANES-1:0][QUO_W-1:0]     quo_next;

  always_comb begin
    logic [DIV_REM_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = DIV_REM_W'(dvs_in[l]) << BIT;
      if (rem_in[l] >= trial) begin
        rem_next[l] = rem_in[l] - trial;
        quo_next[l] = quo_in[l] | QBIT;
      end else begin
        rem_next[l] = rem_in[l];
        quo_next[l] = quo_in[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    dvs_out  <= dvs_in;
    quo_out  <= quo_next;
    side_out <= side_in;
  end

endmodule

@@ src/dmt_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// dmt_cordic_cell
// One micro-rotation of CORDIC vectoring mode, applied to several lanes
// side by side, with a payload carried along unchanged.
// ----------------------------------------------------------------------------
module dmt_cordic_cell
  import dmt_pkg::*;
#(
  parameter int LANES  = 3,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  logic [LANES-1:0][XW-1:0] x_in,
  input  logic [LANES-1:0][XW-1:0] y_in,
  input  logic [LANES-1:0][ZW-1:0] z_in,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     valid_out,
  output logic [LANES-1:0][XW-1:0] x_out,
  output logic [LANES-1:0][XW-1:0] y_out,
  output logic [LANES-1:0][ZW-1:0] z_out,
  output logic [SIDE_W-1:0]        side_out
);

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(STEP));

  logic [LANES-1:0][XW-1:0] x_next;
  logic [LANES-1:0][XW-1:0] y_next;
  logic [LANES-1:0][ZW-1:0] z_next;

  always_comb begin
    logic signed [XW-1:0] xv, yv, dx, dy;
    logic signed [ZW-1:0] zv;
    for (int l = 0; l < LANES; l++) begin
      xv = x_in[l];
      yv = y_in[l];
      zv = z_in[l];
      dx = yv >>> STEP;
      dy = xv >>> STEP;
      if (!yv[XW-1]) begin
        x_next[l] = xv + dx;
        y_next[l] = yv - dy;
        z_next[l] = zv + ANG;
      end else begin
        x_next[l] = xv - dx;
        y_next[l] = yv + dy;
        z_next[l] = zv - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out    <= x_next;
    y_out    <= y_next;
    z_out    <= z_next;
    side_out <= side_in;
  end

endmodule

@@ src/decompose_matrix_to_trs.sv @@
// ----------------------------------------------------------------------------
// decompose_matrix_to_trs
// Splits the upper 3x4 part of a column-major affine matrix in Q16.16 into
// per-axis scale, Euler XYZ angles in radians (Q3.16) and translation.
//
// An item is transferred at a rising edge where start is high and busy is
// low. busy is never raised, so a new item may be transferred in every
// cycle. Each result is shown for exactly one cycle with done high; the
// receiver cannot stall the block.
// The pipeline holds, in order: a squaring register and a summing register,
// a 32-cell square root for the column lengths, a 31-cell divider for
// normalization, a second squaring register and summing register, a 31-cell
// square root, a quadrant fix-up register, the CORDIC cells and one output
// register. Every cell is a full pipeline stage, so throughput is one item
// per cycle.
// Reset clears only the valid flags of the pipeline; items in flight are
// dropped and no done pulse follows until a new item is transferred.
// ----------------------------------------------------------------------------
module decompose_matrix_to_trs
  import dmt_pkg::*;
#(
  parameter int CORDIC_STAGES = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] basis0_x,
  input  logic signed [31:0] basis0_y,
  input  logic signed [31:0] basis0_z,
  input  logic signed [31:0] basis1_x,
  input  logic signed [31:0] basis1_y,
  input  logic signed [31:0] basis1_z,
  input  logic signed [31:0] basis2_x,
  input  logic signed [31:0] basis2_y,
  input  logic signed [31:0] basis2_z,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  output logic               done,
  output logic [31:0]        scale_x,
  output logic [31:0]        scale_y,
  output logic [31:0]        scale_z,
  output logic signed [18:0] angle_x,
  output logic signed [18:0] angle_y,
  output logic signed [18:0] angle_z,
  output logic signed [31:0] out_offset_x,
  output logic signed [31:0] out_offset_y,
  output logic signed [31:0] out_offset_z,
  output logic               degenerate
);

  localparam int LATENCY = 100 + CORDIC_STAGES;

  assign busy = 1'b0;

  logic [2:0][2:0][31:0] in_b;
  assign in_b[0] = {basis0_z, basis0_y, basis0_x};
  assign in_b[1] = {basis1_z, basis1_y, basis1_x};
  assign in_b[2] = {basis2_z, basis2_y, basis2_x};

  logic                  s1_valid;
  logic [2:0][2:0][63:0] s1_sq;
  base_t                 s1_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        s1_sq[c][k] <= 64'(mag32(in_b[c][k])) * 64'(mag32(in_b[c][k]));
      end
    end
    s1_base.b0x    <= basis0_x;
    s1_base.b0y    <= basis0_y;
    s1_base.b0z    <= basis0_z;
    s1_base.b1z    <= basis1_z;
    s1_base.b2z    <= basis2_z;
    s1_base.offset <= {offset_z, offset_y, offset_x};
  end

  logic             s2_valid;
  logic [2:0][63:0] s2_sum;
  logic [2:0][63:0] s2_sum_next;
  sqrt_side_t       s2_side;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_sum_next[c] = s1_sq[c][0] + s1_sq[c][1] + s1_sq[c][2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum <= s2_sum_next;
    for (int c = 0; c < 3; c++) begin
      s2_side.d[c] <= (s2_sum_next[c] == 64'd0);
    end
    s2_side.base <= s1_base;
  end

  logic             sq_vld  [0:SQ_STEPS];
  logic [2:0][63:0] sq_rem  [0:SQ_STEPS];
  logic [2:0][63:0] sq_res  [0:SQ_STEPS];
  sqrt_side_t       sq_side [0:SQ_STEPS];

  assign sq_vld[0]  = s2_valid;
  assign sq_rem[0]  = s2_sum;
  assign sq_res[0]  = '0;
  assign sq_side[0] = s2_side;

  for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_len_sqrt
    dmt_sqrt_cell #(
      .LANES (3),
      .W     (64),
      .STEP  (gi),
      .SIDE_W($bits(sqrt_side_t))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (sq_vld[gi]),
      .rem_in   (sq_rem[gi]),
      .res_in   (sq_res[gi]),
      .side_in  (sq_side[gi]),
      .valid_out(sq_vld[gi+1]),
      .rem_out  (sq_rem[gi+1]),
      .res_out  (sq_res[gi+1]),
      .side_out (sq_side[gi+1])
    );
  end

  logic [2:0][31:0] len;
  base_t            lb;
  logic [4:0][31:0] num_b;
  div_side_t        dv_side0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      len[c] = sq_res[SQ_STEPS][c][31:0];
    end
    lb       = sq_side[SQ_STEPS].base;
    num_b    = {lb.b2z, lb.b1z, lb.b0z, lb.b0y, lb.b0x};
    dv_side0.d      = sq_side[SQ_STEPS].d;
    dv_side0.len    = len;
    dv_side0.offset = lb.offset;
    for (int l = 0; l < 5; l++) begin
      dv_side0.neg[l] = num_b[l][31];
    end
  end

  logic                      dv_vld  [0:DIV_STEPS];
  logic [4:0][DIV_REM_W-1:0] dv_rem  [0:DIV_STEPS];
  logic [4:0][DVS_W-1:0]     dv_dvs  [0:DIV_STEPS];
  logic [4:0][QUO_W-1:0]     dv_quo  [0:DIV_STEPS];
  div_side_t                 dv_side [0:DIV_STEPS];

  for (genvar gl = 0; gl < 5; gl++) begin : g_div_num
    assign dv_rem[0][gl] = DIV_REM_W'(mag32(num_b[gl])) << NORM_SHIFT;
  end

  assign dv_vld[0]  = sq_vld[SQ_STEPS];
  assign dv_dvs[0]  = {len[2], len[1], len[0], len[0], len[0]};
  assign dv_quo[0]  = '0;
  assign dv_side[0] = dv_side0;

  for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_norm_div
    dmt_div_cell #(
      .LANES (5),
      .BIT   (DIV_STEPS - 1 - gi),
      .SIDE_W($bits(div_side_t))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (dv_vld[gi]),
      .rem_in   (dv_rem[gi]),
      .dvs_in   (dv_dvs[gi]),
      .quo_in   (dv_quo[gi]),
      .side_in  (dv_side[gi]),
      .valid_out(dv_vld[gi+1]),
      .rem_out  (dv_rem[gi+1]),
      .dvs_out  (dv_dvs[gi+1]),
      .quo_out  (dv_quo[gi+1]),
      .side_out (dv_side[gi+1])
    );
  end

  logic             s3_valid;
  logic [1:0][61:0] s3_sq;
  ry_side_t         s3_side;
  logic [4:0][31:0] u_next;

  always_comb begin
    for (int l = 0; l < 5; l++) begin
      u_next[l] = dv_side[DIV_STEPS].neg[l] ? (32'd0 - 32'(dv_quo[DIV_STEPS][l]))
                                            : 32'(dv_quo[DIV_STEPS][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    s3_sq[0]       <= 62'(dv_quo[DIV_STEPS][3]) * 62'(dv_quo[DIV_STEPS][3]);
    s3_sq[1]       <= 62'(dv_quo[DIV_STEPS][4]) * 62'(dv_quo[DIV_STEPS][4]);
    s3_side.d      <= dv_side[DIV_STEPS].d;
    s3_side.len    <= dv_side[DIV_STEPS].len;
    s3_side.offset <= dv_side[DIV_STEPS].offset;
    s3_side.u      <= u_next;
  end

  logic       s4_valid;
  logic [61:0] s4_sum;
  ry_side_t   s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_sum  <= s3_sq[0] + s3_sq[1];
    s4_side <= s3_side;
  end

  logic             ry_vld  [0:RY_STEPS];
  logic [0:0][61:0] ry_rem  [0:RY_STEPS];
  logic [0:0][61:0] ry_res  [0:RY_STEPS];
  ry_side_t         ry_side [0:RY_STEPS];

  assign ry_vld[0]    = s4_valid;
  assign ry_rem[0][0] = s4_sum;
  assign ry_res[0]    = '0;
  assign ry_side[0]   = s4_side;

  for (genvar gi = 0; gi < RY_STEPS; gi++) begin : g_ry_sqrt
    dmt_sqrt_cell #(
      .LANES (1),
      .W     (62),
      .STEP  (gi),
      .SIDE_W($bits(ry_side_t))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (ry_vld[gi]),
      .rem_in   (ry_rem[gi]),
      .res_in   (ry_res[gi]),
      .side_in  (ry_side[gi]),
      .valid_out(ry_vld[gi+1]),
      .rem_out  (ry_rem[gi+1]),
      .res_out  (ry_res[gi+1]),
      .side_out (ry_side[gi+1])
    );
  end

  logic                 s5_valid;
  logic [2:0][XW-1:0]   s5_x;
  logic [2:0][XW-1:0]   s5_y;
  logic [2:0][ZW-1:0]   s5_z;
  cordic_side_t         s5_side;
  logic [2:0][XW-1:0]   s5_x_next;
  logic [2:0][XW-1:0]   s5_y_next;
  logic [2:0][ZW-1:0]   s5_z_next;
  logic [2:0]           s5_zero;
  ry_side_t             rs;

  always_comb begin
    logic signed [XW-1:0] px [3];
    logic signed [XW-1:0] py [3];
    rs    = ry_side[RY_STEPS];
    py[0] = XW'(signed'(rs.u[3]));
    px[0] = XW'(signed'(rs.u[4]));
    py[1] = -XW'(signed'(rs.u[2]));
    px[1] = XW'(ry_res[RY_STEPS][0][30:0]);
    py[2] = XW'(signed'(rs.u[1]));
    px[2] = XW'(signed'(rs.u[0]));
    for (int l = 0; l < 3; l++) begin
      s5_zero[l] = (px[l] == '0) && (py[l] == '0);
      if (px[l][XW-1]) begin
        s5_x_next[l] = -px[l];
        s5_y_next[l] = -py[l];
        s5_z_next[l] = py[l][XW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        s5_x_next[l] = px[l];
        s5_y_next[l] = py[l];
        s5_z_next[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= ry_vld[RY_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    s5_x <= s5_x_next;
    s5_y <= s5_y_next;
    s5_z <= s5_z_next;
    s5_side.force_zero[0] <= s5_zero[0] || rs.d[1] || rs.d[2];
    s5_side.force_zero[1] <= s5_zero[1] || rs.d[0] || rs.d[1] || rs.d[2];
    s5_side.force_zero[2] <= s5_zero[2] || rs.d[0];
    s5_side.degen         <= |rs.d;
    s5_side.len           <= rs.len;
    s5_side.offset        <= rs.offset;
  end

  logic               cr_vld  [0:CORDIC_STAGES];
  logic [2:0][XW-1:0] cr_x    [0:CORDIC_STAGES];
  logic [2:0][XW-1:0] cr_y    [0:CORDIC_STAGES];
  logic [2:0][ZW-1:0] cr_z    [0:CORDIC_STAGES];
  cordic_side_t       cr_side [0:CORDIC_STAGES];

  assign cr_vld[0]  = s5_valid;
  assign cr_x[0]    = s5_x;
  assign cr_y[0]    = s5_y;
  assign cr_z[0]    = s5_z;
  assign cr_side[0] = s5_side;

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
    dmt_cordic_cell #(
      .LANES (3),
      .STEP  (gi),
      .SIDE_W($bits(cordic_side_t))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (cr_vld[gi]),
      .x_in     (cr_x[gi]),
      .y_in     (cr_y[gi]),
      .z_in     (cr_z[gi]),
      .side_in  (cr_side[gi]),
      .valid_out(cr_vld[gi+1]),
      .x_out    (cr_x[gi+1]),
      .y_out    (cr_y[gi+1]),
      .z_out    (cr_z[gi+1]),
      .side_out (cr_side[gi+1])
    );
  end

  logic [2:0][18:0] ang_next;
  cordic_side_t     cs;

  always_comb begin
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] r;
    cs = cr_side[CORDIC_STAGES];
    for (int l = 0; l < 3; l++) begin
      zr = cr_z[CORDIC_STAGES][l];
      r  = (zr + ROUND_HALF) >>> ROUND_SHIFT;
      if (r > ANGLE_MAX) begin
        r = ANGLE_MAX;
      end else if (r < -ANGLE_MAX) begin
        r = -ANGLE_MAX;
      end
      ang_next[l] = cs.force_zero[l] ? 19'd0 : r[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    scale_x      <= cs.len[0];
    scale_y      <= cs.len[1];
    scale_z      <= cs.len[2];
    angle_x      <= ang_next[0];
    angle_y      <= ang_next[1];
    angle_z      <= ang_next[2];
    out_offset_x <= cs.offset[0];
    out_offset_y <= cs.offset[1];
    out_offset_z <= cs.offset[2];
    degenerate   <= cs.degen;
  end

`ifndef NO_ASSERTIONS
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transfer in did not produce a result after the pipeline latency");

  a_done_had_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result produced without a matching transfer in");

  a_zero_scale_degenerate: assert property (@(posedge clk) disable iff (rst)
    (done && (scale_x == 32'd0 || scale_y == 32'd0 || scale_z == 32'd0)) |-> degenerate)
    else $error("zero-length column without degenerate flag");

  a_degenerate_angle_y: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (angle_y == 19'sd0))
    else $error("degenerate matrix gave a nonzero y angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_x >= -19'sd205887 && angle_x <= 19'sd205887 &&
              angle_z >= -19'sd205887 && angle_z <= 19'sd205887))
    else $error("angle outside the clamp range");
`endif

endmodule
